[src/h2r_pkg.sv]
// shared types and constants for the hsl to rgb8 converter
package h2r_pkg;

  localparam int unsigned FracBits   = 12;
  localparam int unsigned One        = 1 << FracBits;
  localparam int unsigned LevelW     = FracBits + 1;
  localparam int unsigned HueW       = 15;
  localparam int unsigned HueSextant = 3840;
  localparam int unsigned HueCircle  = 6 * HueSextant;
  localparam int unsigned PosW       = HueW + 1;
  localparam int unsigned WeightW    = 12;
  localparam int unsigned ProdW      = 2 * LevelW;
  localparam int unsigned M2W        = 2 * FracBits + 1;
  localparam int unsigned NumW       = 2 * FracBits + WeightW;
  localparam int unsigned ScaledW    = NumW + 5;
  localparam int unsigned NumLanes   = 3;
  localparam int unsigned NumStages  = 6;

  typedef enum logic [1:0] {
    LaneRed   = 2'd0,
    LaneGreen = 2'd1,
    LaneBlue  = 2'd2
  } lane_e;

  typedef struct packed {
    logic [HueW-1:0]   hue_angle;
    logic [LevelW-1:0] sat_level;
    logic [LevelW-1:0] light_level;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pixel_out_t;

  // hue offset of each lane, in 1/64 degree
  function automatic logic [PosW-1:0] lane_offset(input lane_e lane);
    logic [PosW-1:0] off;
    case (lane)
      LaneRed:  off = PosW'(2 * HueSextant);
      LaneBlue: off = PosW'(4 * HueSextant);
      default:  off = '0;
    endcase
    return off;
  endfunction

endpackage

[src/hsl_to_rgb8_convert_top.sv]
// hsl to 8-bit rgb color converter, six stage pipeline
// throughput: one beat per cycle while out_stall_i is low; each stage holds one beat and moves on when the next is free
// stages: clamp and hue ramp weights, m2 multiply, m1 and span, ramp multiplies, sum, scale
// reset: rst_ni clears all stage valid bits, the pipeline comes up empty
module hsl_to_rgb8_convert_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  h2r_pkg::pixel_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output h2r_pkg::pixel_out_t  out_data_o
);

  localparam int unsigned NS = h2r_pkg::NumStages;
  localparam int unsigned NL = h2r_pkg::NumLanes;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: clamp, hue wrap, per lane ramp weight
  logic [h2r_pkg::HueW-1:0]    hue_w;
  logic [h2r_pkg::LevelW-1:0]  sat_c, lit_c;
  logic [h2r_pkg::PosW-1:0]    pos   [NL];
  logic [h2r_pkg::WeightW-1:0] w_d   [NL];

  always_comb begin
    hue_w = (in_data_i.hue_angle >= h2r_pkg::HueW'(h2r_pkg::HueCircle)) ?
            in_data_i.hue_angle - h2r_pkg::HueW'(h2r_pkg::HueCircle) : in_data_i.hue_angle;
    sat_c = (in_data_i.sat_level > h2r_pkg::LevelW'(h2r_pkg::One)) ?
            h2r_pkg::LevelW'(h2r_pkg::One) : in_data_i.sat_level;
    lit_c = (in_data_i.light_level > h2r_pkg::LevelW'(h2r_pkg::One)) ?
            h2r_pkg::LevelW'(h2r_pkg::One) : in_data_i.light_level;
    for (int c = 0; c < NL; c++) begin
      pos[c] = h2r_pkg::PosW'(hue_w) + h2r_pkg::lane_offset(h2r_pkg::lane_e'(c));
      if (pos[c] >= h2r_pkg::PosW'(h2r_pkg::HueCircle)) begin
        pos[c] = pos[c] - h2r_pkg::PosW'(h2r_pkg::HueCircle);
      end
      if (pos[c] < h2r_pkg::PosW'(h2r_pkg::HueSextant)) begin
        w_d[c] = pos[c][h2r_pkg::WeightW-1:0];
      end else if (pos[c] < h2r_pkg::PosW'(3 * h2r_pkg::HueSextant)) begin
        w_d[c] = h2r_pkg::WeightW'(h2r_pkg::HueSextant);
      end else if (pos[c] < h2r_pkg::PosW'(4 * h2r_pkg::HueSextant)) begin
        w_d[c] = h2r_pkg::WeightW'(h2r_pkg::PosW'(4 * h2r_pkg::HueSextant) - pos[c]);
      end else begin
        w_d[c] = '0;
      end
    end
  end

  logic [h2r_pkg::LevelW-1:0]  s1_lit_q, s1_sat_q;
  logic                        s1_gray_q;
  logic [h2r_pkg::WeightW-1:0] s1_w_q [NL];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_lit_q  <= lit_c;
      s1_sat_q  <= sat_c;
      s1_gray_q <= (sat_c == '0);
      s1_w_q    <= w_d;
    end
  end

  // stage 2: m2 and the gray level
  logic [h2r_pkg::ProdW-1:0]   lxs;
  logic [h2r_pkg::ProdW:0]     m2_full;
  logic [h2r_pkg::LevelW:0]    ls_sum;
  logic [h2r_pkg::LevelW+7:0]  g_full;
  logic [h2r_pkg::M2W-1:0]     m2_d;
  logic [7:0]                  gray_d;

  always_comb begin
    lxs    = s1_lit_q * s1_sat_q;
    ls_sum = (h2r_pkg::LevelW + 1)'(s1_lit_q) + (h2r_pkg::LevelW + 1)'(s1_sat_q);
    if (s1_lit_q < h2r_pkg::LevelW'(h2r_pkg::One / 2)) begin
      m2_full = ((h2r_pkg::ProdW + 1)'(s1_lit_q) << h2r_pkg::FracBits)
              + (h2r_pkg::ProdW + 1)'(lxs);
    end else begin
      m2_full = ((h2r_pkg::ProdW + 1)'(ls_sum) << h2r_pkg::FracBits)
              - (h2r_pkg::ProdW + 1)'(lxs);
    end
    m2_d   = m2_full[h2r_pkg::M2W-1:0];
    g_full = ((h2r_pkg::LevelW + 8)'(s1_lit_q) << 8) - (h2r_pkg::LevelW + 8)'(s1_lit_q);
    gray_d = g_full[h2r_pkg::FracBits+7:h2r_pkg::FracBits];
  end

  logic [h2r_pkg::M2W-1:0]     s2_m2_q;
  logic [h2r_pkg::LevelW-1:0]  s2_lit_q;
  logic [7:0]                  s2_gray_lvl_q;
  logic                        s2_gray_q;
  logic [h2r_pkg::WeightW-1:0] s2_w_q [NL];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_m2_q       <= m2_d;
      s2_lit_q      <= s1_lit_q;
      s2_gray_lvl_q <= gray_d;
      s2_gray_q     <= s1_gray_q;
      s2_w_q        <= s1_w_q;
    end
  end

  // stage 3: m1 and span
  logic [h2r_pkg::M2W:0]   two_l, m2_e, m1_a, m1_b;
  logic [h2r_pkg::M2W-1:0] m1_d, span_d;

  always_comb begin
    two_l  = (h2r_pkg::M2W + 1)'(s2_lit_q) << (h2r_pkg::FracBits + 1);
    m2_e   = (h2r_pkg::M2W + 1)'(s2_m2_q);
    m1_a   = (two_l > m2_e) ? two_l - m2_e : '0;
    m1_b   = (m1_a > m2_e) ? m2_e : m1_a;
    m1_d   = m1_b[h2r_pkg::M2W-1:0];
    span_d = s2_m2_q - m1_d;
  end

  logic [h2r_pkg::M2W-1:0]     s3_m1_q, s3_span_q;
  logic [7:0]                  s3_gray_lvl_q;
  logic                        s3_gray_q;
  logic [h2r_pkg::WeightW-1:0] s3_w_q [NL];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_m1_q       <= m1_d;
      s3_span_q     <= span_d;
      s3_gray_lvl_q <= s2_gray_lvl_q;
      s3_gray_q     <= s2_gray_q;
      s3_w_q        <= s2_w_q;
    end
  end

  // stage 4: base level and ramp products
  logic [h2r_pkg::NumW-1:0] base_d;
  logic [h2r_pkg::NumW-1:0] prod_d [NL];

  always_comb begin
    base_d = (h2r_pkg::NumW'(s3_m1_q) << 12) - (h2r_pkg::NumW'(s3_m1_q) << 8);
    for (int c = 0; c < NL; c++) begin
      prod_d[c] = s3_span_q * s3_w_q[c];
    end
  end

  logic [h2r_pkg::NumW-1:0] s4_base_q;
  logic [h2r_pkg::NumW-1:0] s4_prod_q [NL];
  logic [7:0]               s4_gray_lvl_q;
  logic                     s4_gray_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_base_q     <= base_d;
      s4_prod_q     <= prod_d;
      s4_gray_lvl_q <= s3_gray_lvl_q;
      s4_gray_q     <= s3_gray_q;
    end
  end

  // stage 5: ramp numerators
  logic [h2r_pkg::NumW-1:0] s5_num_q [NL];
  logic [7:0]               s5_gray_lvl_q;
  logic                     s5_gray_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int c = 0; c < NL; c++) begin
        s5_num_q[c] <= s4_base_q + s4_prod_q[c];
      end
      s5_gray_lvl_q <= s4_gray_lvl_q;
      s5_gray_q     <= s4_gray_q;
    end
  end

  // stage 6: times 255 over the full scale is times 17 over 2^32
  logic [h2r_pkg::ScaledW-1:0] x17 [NL];
  logic [7:0]                  chan [NL];

  always_comb begin
    for (int c = 0; c < NL; c++) begin
      x17[c] = (h2r_pkg::ScaledW'(s5_num_q[c]) << 4) + h2r_pkg::ScaledW'(s5_num_q[c]);
      if (x17[c][h2r_pkg::ScaledW-1:32] > (h2r_pkg::ScaledW - 32)'(255)) begin
        chan[c] = 8'hFF;
      end else begin
        chan[c] = x17[c][39:32];
      end
      if (s5_gray_q) begin
        chan[c] = s5_gray_lvl_q;
      end
    end
  end

  h2r_pkg::pixel_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_q.red_out   <= chan[h2r_pkg::LaneRed];
      out_q.green_out <= chan[h2r_pkg::LaneGreen];
      out_q.blue_out  <= chan[h2r_pkg::LaneBlue];
    end
  end

  assign out_data_o = out_q;

endmodule
